[rtl/core/at2d_pkg.sv]
// shared types, constants and helpers for the 2d affine transform unit
package at2d_pkg;

    localparam int WORD_W       = 32;
    localparam int DIM          = 3;
    localparam int FRAC_BITS_DF = 16;
    localparam int COL_W        = $clog2(DIM);

    typedef enum logic [1:0] {
        OP_APPLY   = 2'd0,
        OP_COMPOSE = 2'd1,
        OP_LOAD    = 2'd2,
        OP_IDENT   = 2'd3
    } t_op;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word t_vec [DIM];
    typedef t_word t_mat [DIM][DIM];

    // matrix store control from the issue and merge logic
    typedef struct packed {
        logic             load;
        logic             ident;
        logic             cmp_we;
        logic [COL_W-1:0] cmp_col;
    } t_mat_ctl;

    // fixed-point 1.0 for a given number of fraction bits
    function automatic t_word fx_one(input int frac);
        logic [2*WORD_W-1:0] v;
        begin
            v = 64'd1 << frac;
            return t_word'(v[WORD_W-1:0]);
        end
    endfunction

endpackage

[rtl/core/at2d_lane.sv]
// one dot-product lane: three multipliers, truncation, sum and saturation
module at2d_lane
    import at2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DF
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_vec  i_a,
    input  t_vec  i_b,
    output t_word o_res
);

    localparam int PW = 2 * WORD_W - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam int HW = SW - WORD_W + 1;

    logic signed [2*WORD_W-1:0] prod [DIM];
    logic signed [PW-1:0]       r_p  [DIM];
    logic signed [SW-1:0]       sum;
    logic        [HW-1:0]       hi;
    t_word                      sat;
    t_word                      r_res;

    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            prod[k] = i_a[k] * i_b[k];
        end
    end

    // products truncated toward minus infinity
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIM; k++) begin
                r_p[k] <= PW'(prod[k] >>> FRAC_BITS);
            end
        end
    end

    always_comb begin
        sum = SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]);
        hi  = sum[SW-1:WORD_W-1];
        if ((&hi) || !(|hi)) begin
            sat = sum[WORD_W-1:0];
        end else if (sum[SW-1]) begin
            sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= sat;
        end
    end

    assign o_res = r_res;

endmodule

[rtl/core/at2d_mat.sv]
// current matrix store with load, identity and column-wise compose commit
module at2d_mat
    import at2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mat_ctl i_ctl,
    input  t_mat     i_ld,
    input  t_vec     i_res,
    output t_mat     o_m
);

    localparam t_word ONE = fx_one(FRAC_BITS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(DIM - 1);

    t_mat  r_m;
    t_word r_buf [DIM][DIM-1];
    logic  last;

    assign last = i_ctl.cmp_we && (i_ctl.cmp_col == LAST_COL);

    // earlier columns of a compose wait here until the last one arrives
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_we) begin
            for (int r = 0; r < DIM; r++) begin
                for (int j = 0; j < DIM - 2; j++) begin
                    r_buf[r][j] <= r_buf[r][j+1];
                end
                r_buf[r][DIM-2] <= i_res[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.ident) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_m[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (i_ctl.load) begin
            r_m <= i_ld;
        end else if (last) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM - 1; c++) begin
                    r_m[r][c] <= r_buf[r][c];
                end
                r_m[r][DIM-1] <= i_res[r];
            end
        end
    end

    assign o_m = r_m;

endmodule

[rtl/core/affine_2d_transform_unit.sv]
// top level of the 2d affine transform unit: issue stage, lanes, merge and output
//
// channel   direction  handshake          payload
// command   in         i_valid / o_stall  i_opcode, i_point_x, i_point_y, i_m_r0c0..i_m_r2c2
// result    out        o_valid / i_stall  o_out_x, o_out_y
//
// apply items stream at one per cycle unless a result stall or a compose in flight holds them
// compose issues one matrix column per cycle across three lanes while the output is not stalled
// and holds back the next item until the new matrix is committed
// load and identity wait for a compose still in flight
// reset is synchronous active low and restores the identity matrix
// a stalled result freezes the lane pipeline; the input side keeps one item buffered
module affine_2d_transform_unit
    import at2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  t_word       i_point_x,
    input  t_word       i_point_y,
    input  t_word       i_m_r0c0,
    input  t_word       i_m_r0c1,
    input  t_word       i_m_r0c2,
    input  t_word       i_m_r1c0,
    input  t_word       i_m_r1c1,
    input  t_word       i_m_r1c2,
    input  t_word       i_m_r2c0,
    input  t_word       i_m_r2c1,
    input  t_word       i_m_r2c2,
    output logic        o_valid,
    input  logic        i_stall,
    output t_word       o_out_x,
    output t_word       o_out_y
);

    localparam t_word ONE = fx_one(FRAC_BITS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(DIM - 1);

    // issue stage: holds the accepted item
    logic             r_s0_valid;
    t_op              r_s0_op;
    t_word            r_s0_px;
    t_word            r_s0_py;
    t_mat             r_s0_m;
    logic [COL_W-1:0] r_s0_col;

    // control riding along with the lane product and sum stages
    logic             r_p_valid;
    t_op              r_p_op;
    logic [COL_W-1:0] r_p_col;
    logic             r_q_valid;
    t_op              r_q_op;
    logic [COL_W-1:0] r_q_col;

    // output register
    logic             r_out_valid;
    t_word            r_out_x;
    t_word            r_out_y;

    logic     en;
    logic     pend;
    logic     issue;
    logic     s0_done;
    logic     in_acc;
    t_mat     cur_m;
    t_vec     lane_b;
    t_vec     lane_res;
    t_mat_ctl mat_ctl;

    // whole lane pipeline moves unless a finished result is stuck
    assign en = !(r_out_valid && i_stall);

    // a compose in flight has not committed its matrix yet
    assign pend = (r_p_valid && (r_p_op == OP_COMPOSE)) ||
                  (r_q_valid && (r_q_op == OP_COMPOSE));

    // later columns of the same compose do not wait on themselves
    assign issue   = r_s0_valid && en && ((r_s0_col != '0) || !pend);
    assign s0_done = issue && ((r_s0_op != OP_COMPOSE) || (r_s0_col == LAST_COL));
    assign o_stall = r_s0_valid && !s0_done;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s0_col   <= '0;
        end else begin
            if (in_acc) begin
                r_s0_valid <= 1'b1;
            end else if (s0_done) begin
                r_s0_valid <= 1'b0;
            end
            if (s0_done) begin
                r_s0_col <= '0;
            end else if (issue) begin
                r_s0_col <= r_s0_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_op      <= t_op'(i_opcode);
            r_s0_px      <= i_point_x;
            r_s0_py      <= i_point_y;
            r_s0_m[0][0] <= i_m_r0c0;
            r_s0_m[0][1] <= i_m_r0c1;
            r_s0_m[0][2] <= i_m_r0c2;
            r_s0_m[1][0] <= i_m_r1c0;
            r_s0_m[1][1] <= i_m_r1c1;
            r_s0_m[1][2] <= i_m_r1c2;
            r_s0_m[2][0] <= i_m_r2c0;
            r_s0_m[2][1] <= i_m_r2c1;
            r_s0_m[2][2] <= i_m_r2c2;
        end
    end

    // apply multiplies by (x, y, 1.0); compose by one column of the supplied matrix
    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            lane_b[k] = r_s0_m[k][r_s0_col];
        end
        if (r_s0_op == OP_APPLY) begin
            lane_b[0] = r_s0_px;
            lane_b[1] = r_s0_py;
            lane_b[2] = ONE;
        end
    end

    // lane r works on row r of the current matrix
    for (genvar r = 0; r < DIM; r++) begin : g_lane
        at2d_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (cur_m[r]),
            .i_b   (lane_b),
            .o_res (lane_res[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= issue && ((r_s0_op == OP_APPLY) || (r_s0_op == OP_COMPOSE));
            r_q_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_op  <= r_s0_op;
            r_p_col <= r_s0_col;
            r_q_op  <= r_p_op;
            r_q_col <= r_p_col;
        end
    end

    // merge: apply results go out, compose columns go to the matrix store
    always_comb begin
        mat_ctl.load    = issue && (r_s0_op == OP_LOAD);
        mat_ctl.ident   = issue && (r_s0_op == OP_IDENT);
        mat_ctl.cmp_we  = en && r_q_valid && (r_q_op == OP_COMPOSE);
        mat_ctl.cmp_col = r_q_col;
    end

    at2d_mat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mat_ctl),
        .i_ld    (r_s0_m),
        .i_res   (lane_res),
        .o_m     (cur_m)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_q_valid && (r_q_op == OP_APPLY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_q_valid && (r_q_op == OP_APPLY)) begin
            r_out_x <= lane_res[0];
            r_out_y <= lane_res[1];
        end
    end

    assign o_valid = r_out_valid;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

endmodule

[rtl/core/at2d_chk.sv]
// port-level checker for the 2d affine transform unit, bound to the top level
module at2d_chk
    import at2d_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_valid,
    input logic  o_stall,
    input logic  o_valid,
    input logic  i_stall,
    input t_word o_out_x,
    input t_word o_out_y
);

    // reset empties both the input buffer and the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output or input stall active after reset");

    // input stall only comes from an item already taken in
    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ($past(o_stall) || $past(i_valid && !o_stall)))
        else $error("input stall without a buffered item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_out_x) && $stable(o_out_y)))
        else $error("result changed while stalled");

endmodule

bind affine_2d_transform_unit at2d_chk u_at2d_chk (.*);

[verif/tb_top.sv]
// self-checking testbench for the 2d affine transform unit
module tb_top;
    import at2d_pkg::*;

    localparam int     FRAC        = FRAC_BITS_DF;
    localparam t_word  FX_ONE      = t_word'(64'd1 << FRAC);
    localparam t_word  W_MAX       = 32'sh7fffffff;
    localparam t_word  W_MIN       = 32'sh80000000;
    localparam longint SUM_MAX     = 64'sd2147483647;
    localparam longint SUM_MIN     = -64'sd2147483648;
    localparam int     HOLD_CYCLES = 300;
    localparam int     SETTLE      = 16;
    localparam int     SHOW_LIMIT  = 10;

    // supplied matrix, row-major, entry 0 is row 0 column 0
    typedef logic [DIM*DIM-1:0][WORD_W-1:0] t_mat_flat;

    typedef struct {
        t_word x;
        t_word y;
    } t_point;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       i_valid  = 1'b0;
    logic       i_stall  = 1'b0;
    logic [1:0] i_opcode = 2'd0;
    t_word      i_point_x = '0;
    t_word      i_point_y = '0;
    t_word      i_m_r0c0 = '0;
    t_word      i_m_r0c1 = '0;
    t_word      i_m_r0c2 = '0;
    t_word      i_m_r1c0 = '0;
    t_word      i_m_r1c1 = '0;
    t_word      i_m_r1c2 = '0;
    t_word      i_m_r2c0 = '0;
    t_word      i_m_r2c1 = '0;
    t_word      i_m_r2c2 = '0;
    logic       o_stall;
    logic       o_valid;
    t_word      o_out_x;
    t_word      o_out_y;

    // predictor state: the current transform and the points still owed
    t_word  model_m [DIM*DIM];
    t_point xform_due [$];

    int fault_count    = 0;
    int points_checked = 0;
    int op_count [4]   = '{0, 0, 0, 0};

    // idling knobs: idle and stall percent of cycles, and a requested stall hold
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    affine_2d_transform_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_opcode  (i_opcode),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_m_r0c0  (i_m_r0c0),
        .i_m_r0c1  (i_m_r0c1),
        .i_m_r0c2  (i_m_r0c2),
        .i_m_r1c0  (i_m_r1c0),
        .i_m_r1c1  (i_m_r1c1),
        .i_m_r1c2  (i_m_r1c2),
        .i_m_r2c0  (i_m_r2c0),
        .i_m_r2c1  (i_m_r2c1),
        .i_m_r2c2  (i_m_r2c2),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // exact product, then floor to the fraction width
    function automatic longint fx_floor_mul(input t_word a, input t_word b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC;
    endfunction

    function automatic t_word dot_row(input t_word a0, input t_word a1, input t_word a2,
                                      input t_word b0, input t_word b1, input t_word b2);
        longint acc;
        acc = fx_floor_mul(a0, b0) + fx_floor_mul(a1, b1) + fx_floor_mul(a2, b2);
        if (acc > SUM_MAX) begin
            return W_MAX;
        end
        if (acc < SUM_MIN) begin
            return W_MIN;
        end
        return t_word'(acc);
    endfunction

    task automatic set_model_identity;
        for (int i = 0; i < DIM*DIM; i++) begin
            model_m[i] = (i % (DIM+1) == 0) ? FX_ONE : t_word'(0);
        end
    endtask

    task automatic predict_command(input t_op op, input t_word px, input t_word py,
                                   input t_mat_flat sm);
        t_word  s    [DIM*DIM];
        t_word  prod [DIM*DIM];
        t_point pt;
        for (int i = 0; i < DIM*DIM; i++) begin
            s[i] = t_word'(sm[i]);
        end
        case (op)
            OP_APPLY: begin
                pt.x = dot_row(model_m[0], model_m[1], model_m[2], px, py, FX_ONE);
                pt.y = dot_row(model_m[3], model_m[4], model_m[5], px, py, FX_ONE);
                xform_due.push_back(pt);
            end
            OP_COMPOSE: begin
                for (int r = 0; r < DIM; r++) begin
                    for (int c = 0; c < DIM; c++) begin
                        prod[r*DIM+c] = dot_row(model_m[r*DIM], model_m[r*DIM+1],
                                                model_m[r*DIM+2], s[c], s[DIM+c],
                                                s[2*DIM+c]);
                    end
                end
                model_m = prod;
            end
            OP_LOAD: begin
                model_m = s;
            end
            default: begin
                set_model_identity();
            end
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_word rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            // values within about +-2.0
            return t_word'($urandom_range(0, 262143)) - 32'sd131072;
        end else if (pick < 8) begin
            return t_word'($urandom);
        end else if (pick < 9) begin
            case ($urandom_range(0, 3))
                0:       return W_MAX;
                1:       return W_MIN;
                2:       return t_word'(0);
                default: return t_word'(-1);
            endcase
        end
        return $urandom_range(0, 1) ? FX_ONE : -FX_ONE;
    endfunction

    function automatic t_mat_flat rand_mat();
        t_mat_flat m;
        for (int i = 0; i < DIM*DIM; i++) begin
            m[i] = rand_word();
        end
        // half of the time a proper affine matrix with bottom row 0 0 1
        if ($urandom_range(0, 1)) begin
            m[6] = '0;
            m[7] = '0;
            m[8] = FX_ONE;
        end
        return m;
    endfunction

    function automatic t_mat_flat mat_fill(input t_word v);
        t_mat_flat m;
        for (int i = 0; i < DIM*DIM; i++) begin
            m[i] = v;
        end
        return m;
    endfunction

    function automatic t_mat_flat mat_diag(input t_word d);
        t_mat_flat m;
        for (int i = 0; i < DIM*DIM; i++) begin
            m[i] = (i % (DIM+1) == 0) ? d : t_word'(0);
        end
        return m;
    endfunction

    // drives one item at the falling edge and waits for the accepting rising edge
    task automatic send_command(input t_op op, input t_word px, input t_word py,
                                input t_mat_flat sm);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_point_x <= px;
        i_point_y <= py;
        i_m_r0c0  <= sm[0];
        i_m_r0c1  <= sm[1];
        i_m_r0c2  <= sm[2];
        i_m_r1c0  <= sm[3];
        i_m_r1c1  <= sm[4];
        i_m_r1c2  <= sm[5];
        i_m_r2c0  <= sm[6];
        i_m_r2c1  <= sm[7];
        i_m_r2c2  <= sm[8];
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_command(op, px, py, sm);
        op_count[op]++;
    endtask

    task automatic send_apply(input t_word px, input t_word py);
        send_command(OP_APPLY, px, py, rand_mat());
    endtask

    // sender goes quiet until every owed point has come back
    task automatic wait_results_settled;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (xform_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // ---------------------------------------------------------------- receiver

    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic note_fault(input string what, input t_word want, input t_word got);
        fault_count++;
        if (fault_count <= SHOW_LIMIT) begin
            $display("mismatch on %s: expected %0d (%h) got %0d (%h)",
                     what, want, want, got, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_point want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (xform_due.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT) begin
                    $display("unexpected point: got x %h y %h with nothing owed",
                             o_out_x, o_out_y);
                end
            end else begin
                want = xform_due.pop_front();
                if (o_out_x !== want.x) begin
                    note_fault("out_x", want.x, o_out_x);
                end
                if (o_out_y !== want.y) begin
                    note_fault("out_y", want.y, o_out_y);
                end
                points_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // identity after reset passes points through unchanged
    task automatic test_reset_identity;
        send_apply(t_word'(0), t_word'(0));
        send_apply(W_MAX, W_MIN);
        send_apply(t_word'(-1), t_word'(1));
        send_apply(W_MIN, W_MAX);
    endtask

    // dot products beyond 32 bits clamp, in points and in composed elements
    task automatic test_saturation;
        send_command(OP_LOAD, rand_word(), rand_word(), mat_fill(W_MAX));
        send_apply(W_MAX, W_MAX);
        send_apply(W_MIN, W_MAX);
        send_command(OP_LOAD, rand_word(), rand_word(), mat_fill(W_MIN));
        send_apply(W_MIN, W_MIN);
        send_apply(W_MAX, W_MAX);
        send_command(OP_LOAD, t_word'(0), t_word'(0), mat_fill(W_MAX));
        send_command(OP_COMPOSE, t_word'(0), t_word'(0), mat_fill(W_MAX));
        send_apply(FX_ONE, -FX_ONE);
        send_command(OP_COMPOSE, t_word'(0), t_word'(0), mat_fill(W_MIN));
        send_apply(FX_ONE, FX_ONE);
    endtask

    // negative products round toward minus infinity
    task automatic test_floor_truncation;
        t_mat_flat shift;
        send_command(OP_LOAD, t_word'(0), t_word'(0), mat_diag(t_word'(-1)));
        send_apply(t_word'(1), t_word'(1));
        send_apply(t_word'(3), t_word'(-5));
        send_command(OP_LOAD, t_word'(0), t_word'(0), mat_diag(t_word'(1)));
        send_apply(W_MAX, W_MIN);
        shift    = mat_diag(FX_ONE);
        shift[2] = 3 * FX_ONE;
        shift[5] = -2 * FX_ONE;
        send_command(OP_LOAD, t_word'(0), t_word'(0), shift);
        send_apply(FX_ONE, FX_ONE);
    endtask

    // fields an opcode does not use must not matter
    task automatic test_ignored_fields;
        send_command(OP_IDENT, rand_word(), rand_word(), rand_mat());
        send_command(OP_APPLY, t_word'($urandom), t_word'($urandom), rand_mat());
        send_command(OP_LOAD, t_word'($urandom), t_word'($urandom), mat_fill(t_word'(0)));
        send_apply(t_word'($urandom), t_word'($urandom));
        send_command(OP_IDENT, t_word'($urandom), t_word'($urandom), mat_fill(W_MIN));
    endtask

    // mostly points, with matrix updates mixed in
    task automatic test_random_commands(input int count);
        int unsigned pick;
        t_op         op;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                op = OP_APPLY;
            end else if (pick < 80) begin
                op = OP_COMPOSE;
            end else if (pick < 92) begin
                op = OP_LOAD;
            end else begin
                op = OP_IDENT;
            end
            send_command(op, rand_word(), rand_word(), rand_mat());
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_hold_off;
        set_idling(0, 0);
        hold_req = HOLD_CYCLES;
        for (int n = 0; n < 80; n++) begin
            if (n == 30) begin
                send_command(OP_COMPOSE, rand_word(), rand_word(), rand_mat());
            end else if (n == 50) begin
                send_command(OP_LOAD, rand_word(), rand_word(), rand_mat());
            end else begin
                send_apply(rand_word(), rand_word());
            end
        end
        wait_results_settled();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        set_model_identity();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_identity();
        test_saturation();
        test_floor_truncation();
        test_ignored_fields();
        wait_results_settled();

        set_idling(0, 0);
        test_random_commands(340);
        wait_results_settled();
        set_idling(57, 0);
        test_random_commands(340);
        wait_results_settled();
        set_idling(0, 57);
        test_random_commands(340);
        wait_results_settled();
        set_idling(14, 14);
        test_random_commands(340);

        test_output_hold_off();

        wait_results_settled();
        repeat (SETTLE) @(posedge i_clk);

        $display("run covered %0d items: %0d apply, %0d compose, %0d load, %0d identity",
                 op_count[OP_APPLY] + op_count[OP_COMPOSE] + op_count[OP_LOAD]
                 + op_count[OP_IDENT], op_count[OP_APPLY], op_count[OP_COMPOSE],
                 op_count[OP_LOAD], op_count[OP_IDENT]);
        $display("%0d points checked over corner values, saturation, floor rounding, %s",
                 points_checked, "four idling mixes and a long output hold-off");
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", fault_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2000000;
        $display("timed out with %0d points still owed", xform_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
